// ===== rtl/core/tvs_pkg.sv =====
// Shared types, constants and arithmetic helpers for the trilinear volume sampler.
// Every module of the sampler core refers to this package by scoped names.
package tvs_pkg;

  // Volume geometry and field widths.
  localparam int MAX_EDGE   = 32;
  localparam int VOXEL_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int COORD_W    = 16;
  localparam int INT_W      = COORD_W - FRAC_W;
  localparam int SIZE_W     = 6;
  localparam int ORG_W      = 6;
  localparam int IDX_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VOL_DEPTH  = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int ADDR_W     = $clog2(VOL_DEPTH);
  localparam int LOC_W      = INT_W + 2;
  localparam int N_CORNER   = 8;
  localparam int N_BANK     = N_CORNER / 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_X_ORG   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORG   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_Z_ORG   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE = CFG_IDX_W'(6);

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0]  RST_SIZE    = SIZE_W'(MAX_EDGE);
  localparam logic [ORG_W-1:0]   RST_ORG     = ORG_W'(-16);
  localparam logic [VOXEL_W-1:0] RST_OUTSIDE = '0;

  typedef struct packed {
    logic [SIZE_W-1:0]  x_size;
    logic [SIZE_W-1:0]  y_size;
    logic [SIZE_W-1:0]  z_size;
    logic [ORG_W-1:0]   x_org;
    logic [ORG_W-1:0]   y_org;
    logic [ORG_W-1:0]   z_org;
    logic [VOXEL_W-1:0] outside;
  } tvs_cfg_t;

  // Request to the voxel store copies, issued as an item leaves the address stage.
  typedef struct packed {
    logic                             we;
    logic [ADDR_W-1:0]                waddr;
    logic [VOXEL_W-1:0]               wdata;
    logic                             re;
    logic [N_CORNER-1:0][ADDR_W-1:0]  raddr;
  } tvs_ram_req_t;

  // Sample handed from the address stages to the interpolation stages.
  // inb holds {z_hi, z_lo, y_hi, y_lo, x_hi, x_lo} in-range flags.
  typedef struct packed {
    logic              vld;
    logic [5:0]        inb;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic [FRAC_W-1:0] fz;
  } tvs_fwd_t;

  // A stored size above the store edge is saturated.
  function automatic logic [SIZE_W-1:0] sat_size(input logic [CFG_DATA_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v[SIZE_W-1:0];
    return (int'(s) > MAX_EDGE) ? SIZE_W'(MAX_EDGE) : s;
  endfunction

  // Local index of the floored coordinate relative to the origin.
  function automatic logic signed [LOC_W-1:0] loc_of(input logic [INT_W-1:0] ip,
                                                      input logic [ORG_W-1:0] org);
    return LOC_W'($signed(ip)) - LOC_W'($signed(org));
  endfunction

  // In-range flags of the low and high corner along one axis: {hi, lo}.
  function automatic logic [1:0] range_ok(input logic signed [LOC_W-1:0] l,
                                          input logic [SIZE_W-1:0] size);
    logic signed [LOC_W-1:0] lim;
    logic signed [LOC_W-1:0] one;
    logic lo_ok;
    logic hi_ok;
    lim   = $signed(LOC_W'(size));
    one   = $signed(LOC_W'(1));
    lo_ok = (l >= $signed(LOC_W'(0))) && (l < lim);
    hi_ok = (l >= -one) && (l < lim - one);
    return {hi_ok, lo_ok};
  endfunction

  // One linear step: lo + (hi - lo) * f / 2^FRAC_W, the quotient rounded toward zero.
  function automatic logic [VOXEL_W-1:0] lerp(input logic [VOXEL_W-1:0] lo,
                                               input logic [VOXEL_W-1:0] hi,
                                               input logic [FRAC_W-1:0] f);
    logic signed [VOXEL_W:0]          diff;
    logic signed [VOXEL_W+FRAC_W+1:0] prod;
    logic signed [VOXEL_W+FRAC_W+1:0] adj;
    diff = $signed({hi[VOXEL_W-1], hi}) - $signed({lo[VOXEL_W-1], lo});
    prod = diff * $signed({1'b0, f});
    adj  = prod[VOXEL_W+FRAC_W+1]
         ? prod + $signed({{(VOXEL_W+2){1'b0}}, {FRAC_W{1'b1}}})
         : prod;
    return lo + adj[FRAC_W +: VOXEL_W];
  endfunction

endpackage

// ===== rtl/core/tvs_ram.sv =====
// One copy of the voxel store: one write port and two registered read ports.
// Depth and widths come from tvs_pkg.
module tvs_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tvs_pkg::ADDR_W-1:0]  waddr,
  input  logic [tvs_pkg::VOXEL_W-1:0] wdata,
  input  logic                       re,
  input  logic [tvs_pkg::ADDR_W-1:0]  raddr_a,
  input  logic [tvs_pkg::ADDR_W-1:0]  raddr_b,
  output logic [tvs_pkg::VOXEL_W-1:0] rdata_a,
  output logic [tvs_pkg::VOXEL_W-1:0] rdata_b
);

  logic [tvs_pkg::VOXEL_W-1:0] mem_r [tvs_pkg::VOL_DEPTH];
  logic [tvs_pkg::VOXEL_W-1:0] rdata_a_r;
  logic [tvs_pkg::VOXEL_W-1:0] rdata_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read ports; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/core/tvs_front.sv =====
// Address stages of the sampler: coordinate split, range checks and corner addressing.
// Issues voxel writes and corner reads to the store copies; uses tvs_pkg.
module tvs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [tvs_pkg::IDX_W-1:0]     in_voxel_index,
  input  logic [tvs_pkg::VOXEL_W-1:0]   in_voxel_value,
  input  logic [tvs_pkg::COORD_W-1:0]   in_sample_x,
  input  logic [tvs_pkg::COORD_W-1:0]   in_sample_y,
  input  logic [tvs_pkg::COORD_W-1:0]   in_sample_z,
  input  tvs_pkg::tvs_cfg_t             cfg,
  input  logic                          s4_ready,
  output tvs_pkg::tvs_ram_req_t         ram_req,
  output tvs_pkg::tvs_fwd_t             fwd
);

  typedef struct packed {
    logic                         smp;
    logic [tvs_pkg::IDX_W-1:0]    idx;
    logic [tvs_pkg::VOXEL_W-1:0]  val;
    logic [5:0]                   inb;
    logic [tvs_pkg::FRAC_W-1:0]   fx;
    logic [tvs_pkg::FRAC_W-1:0]   fy;
    logic [tvs_pkg::FRAC_W-1:0]   fz;
  } item_t;

  logic                              v1_r, v2_r, v3_r;
  item_t                             it1_r, it2_r, it3_r;
  item_t                             it_in;
  logic signed [tvs_pkg::LOC_W-1:0]  lx_in, ly_in, lz_in;
  logic signed [tvs_pkg::LOC_W-1:0]  lx1_r, ly1_r, lz1_r;
  logic signed [tvs_pkg::LOC_W-1:0]  lx2_r;
  logic [tvs_pkg::ADDR_W-1:0]        row2_r, area2_r;
  logic [tvs_pkg::ADDR_W-1:0]        base3_r, area3_r;
  logic [tvs_pkg::ADDR_W-1:0]        xs_a, ys_a;
  logic                              rdy1, rdy2, rdy3, adv3;

  // Size registers widened to address width.
  assign xs_a = tvs_pkg::ADDR_W'(cfg.x_size);
  assign ys_a = tvs_pkg::ADDR_W'(cfg.y_size);

  // Floor each coordinate, keep its fraction, and place it against the origin.
  always_comb begin
    lx_in     = tvs_pkg::loc_of(in_sample_x[tvs_pkg::COORD_W-1:tvs_pkg::FRAC_W], cfg.x_org);
    ly_in     = tvs_pkg::loc_of(in_sample_y[tvs_pkg::COORD_W-1:tvs_pkg::FRAC_W], cfg.y_org);
    lz_in     = tvs_pkg::loc_of(in_sample_z[tvs_pkg::COORD_W-1:tvs_pkg::FRAC_W], cfg.z_org);
    it_in.smp = in_mode;
    it_in.idx = in_voxel_index;
    it_in.val = in_voxel_value;
    it_in.inb = {tvs_pkg::range_ok(lz_in, cfg.z_size),
                 tvs_pkg::range_ok(ly_in, cfg.y_size),
                 tvs_pkg::range_ok(lx_in, cfg.x_size)};
    it_in.fx  = in_sample_x[tvs_pkg::FRAC_W-1:0];
    it_in.fy  = in_sample_y[tvs_pkg::FRAC_W-1:0];
    it_in.fz  = in_sample_z[tvs_pkg::FRAC_W-1:0];
  end

  // Stage flow: a write leaves the last stage without needing room downstream.
  assign adv3     = v3_r && (!it3_r.smp || s4_ready);
  assign rdy3     = !v3_r || !it3_r.smp || s4_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage 1 captures the beat with its local indices.
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      it1_r <= it_in;
      lx1_r <= lx_in;
      ly1_r <= ly_in;
      lz1_r <= lz_in;
    end
  end

  // Stage 2 forms the row index z*y_size + y and the slice area, modulo store depth.
  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      it2_r   <= it1_r;
      lx2_r   <= lx1_r;
      row2_r  <= tvs_pkg::ADDR_W'(tvs_pkg::ADDR_W'(lz1_r) * ys_a)
               + tvs_pkg::ADDR_W'(ly1_r);
      area2_r <= tvs_pkg::ADDR_W'(xs_a * ys_a);
    end
  end

  // Stage 3 forms the address of the lowest corner.
  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      it3_r   <= it2_r;
      base3_r <= tvs_pkg::ADDR_W'(row2_r * xs_a) + tvs_pkg::ADDR_W'(lx2_r);
      area3_r <= area2_r;
    end
  end

  // Store access: writes and reads share this stage, so program order is kept.
  always_comb begin
    ram_req.we    = adv3 && !it3_r.smp
                 && ({1'b0, it3_r.idx} < (tvs_pkg::IDX_W + 1)'(tvs_pkg::VOL_DEPTH));
    ram_req.waddr = tvs_pkg::ADDR_W'(it3_r.idx);
    ram_req.wdata = it3_r.val;
    ram_req.re    = adv3 && it3_r.smp;
    for (int c = 0; c < tvs_pkg::N_CORNER; c++) begin
      ram_req.raddr[c] = base3_r
                       + (((c & 1) != 0) ? tvs_pkg::ADDR_W'(1) : '0)
                       + (((c & 2) != 0) ? xs_a : '0)
                       + (((c & 4) != 0) ? area3_r : '0);
    end
  end

  // Hand the sample to the interpolation stages.
  always_comb begin
    fwd.vld = adv3 && it3_r.smp;
    fwd.inb = it3_r.inb;
    fwd.fx  = it3_r.fx;
    fwd.fy  = it3_r.fy;
    fwd.fz  = it3_r.fz;
  end

  // An accepted beat always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted beat did not enter the first stage");

  // A stalled sample must not touch the store.
  a_stall_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && it3_r.smp && !s4_ready) |-> !(ram_req.re || ram_req.we))
    else $error("store accessed by a stalled sample");

  // A write never forwards a sample downstream.
  a_write_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !fwd.vld)
    else $error("write beat forwarded as a sample");

endmodule

// ===== rtl/core/tvs_interp.sv =====
// Interpolation stages of the sampler: outside substitution and seven linear steps.
// Takes corner data from the store copies and flags from tvs_front; uses tvs_pkg.
module tvs_interp (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  tvs_pkg::tvs_fwd_t                                fwd,
  input  logic [tvs_pkg::N_CORNER-1:0][tvs_pkg::VOXEL_W-1:0] corner_data,
  input  logic [tvs_pkg::VOXEL_W-1:0]                      outside,
  output logic                                             s4_ready,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic [tvs_pkg::VOXEL_W-1:0]                      out_sample_value
);

  logic                                              v4_r, v5_r, v6_r, out_valid_r;
  logic [5:0]                                        inb4_r;
  logic [tvs_pkg::FRAC_W-1:0]                        fx4_r, fy4_r, fz4_r;
  logic [tvs_pkg::FRAC_W-1:0]                        fy5_r, fz5_r, fz6_r;
  logic [tvs_pkg::N_CORNER-1:0][tvs_pkg::VOXEL_W-1:0] d4;
  logic [tvs_pkg::VOXEL_W-1:0]                       a5_r, b5_r, c5_r, d5_r;
  logic [tvs_pkg::VOXEL_W-1:0]                       e6_r, g6_r;
  logic [tvs_pkg::VOXEL_W-1:0]                       out_sample_value_r;
  logic                                              rdy4, rdy5, rdy6, rdy_out;

  // Stage flow towards the output register.
  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy6     = !v6_r || rdy_out;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign s4_ready = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= fwd.vld;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
      if (rdy6) begin
        v6_r <= v5_r;
      end
      if (rdy_out) begin
        out_valid_r <= v6_r;
      end
    end
  end

  // Stage 4 side data; the corners arrive from the store on the same edge.
  always_ff @(posedge clk) begin
    if (fwd.vld) begin
      inb4_r <= fwd.inb;
      fx4_r  <= fwd.fx;
      fy4_r  <= fwd.fy;
      fz4_r  <= fwd.fz;
    end
  end

  // Corners beyond the configured box take the outside value.
  always_comb begin
    for (int c = 0; c < tvs_pkg::N_CORNER; c++) begin
      d4[c] = (inb4_r[(c & 1)] && inb4_r[2 + ((c >> 1) & 1)] && inb4_r[4 + ((c >> 2) & 1)])
            ? corner_data[c] : outside;
    end
  end

  // Four steps along x.
  always_ff @(posedge clk) begin
    if (v4_r && rdy5) begin
      a5_r  <= tvs_pkg::lerp(d4[0], d4[1], fx4_r);
      c5_r  <= tvs_pkg::lerp(d4[2], d4[3], fx4_r);
      b5_r  <= tvs_pkg::lerp(d4[4], d4[5], fx4_r);
      d5_r  <= tvs_pkg::lerp(d4[6], d4[7], fx4_r);
      fy5_r <= fy4_r;
      fz5_r <= fz4_r;
    end
  end

  // Two steps along y.
  always_ff @(posedge clk) begin
    if (v5_r && rdy6) begin
      e6_r  <= tvs_pkg::lerp(a5_r, c5_r, fy5_r);
      g6_r  <= tvs_pkg::lerp(b5_r, d5_r, fy5_r);
      fz6_r <= fz5_r;
    end
  end

  // Final step along z into the output register.
  always_ff @(posedge clk) begin
    if (v6_r && rdy_out) begin
      out_sample_value_r <= tvs_pkg::lerp(e6_r, g6_r, fz6_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_value_r;

  // The address stages only push a sample when stage 4 has room.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    fwd.vld |-> s4_ready)
    else $error("sample pushed into a full stage 4");

  // While stage 4 is held, the store read data under it must not change.
  a_corners_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy5) |=> $stable(corner_data))
    else $error("corner data changed under a stalled sample");

endmodule

// ===== rtl/core/trilinear_volume_sampler_core.sv =====
// Top level of the trilinear volume sampler: configuration registers, store copies,
// address stages and interpolation stages. Depends on tvs_pkg, tvs_front, tvs_ram, tvs_interp.
//
// Use:
//   Input channel (in_*): one beat per item. in_mode 0 writes in_voxel_value at
//   in_voxel_index; in_mode 1 samples at the signed Q8.8 point (in_sample_x/y/z).
//   Writes give no result; each sample gives one beat on the output channel.
//   Configuration channel (cfg_*): cfg_index selects the register, cfg_wdata is the
//   value; cfg_ready is always high. Write it only while no item is in flight.
//   Throughput: one item per clock while results are taken. All eight corners
//   are read in the same cycle from four copies of the voxel store, each with
//   two read ports.
//   Reset: pipeline emptied, registers at their reset values; store contents are
//   undefined until written, with no clearing pass.
//   Stall: a held result sits in the output register; earlier stages keep filling
//   until every stage holds a beat and stage 3 holds a sample, then in_ready falls.
module trilinear_volume_sampler_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [tvs_pkg::IDX_W-1:0]       in_voxel_index,
  input  logic [tvs_pkg::VOXEL_W-1:0]     in_voxel_value,
  input  logic [tvs_pkg::COORD_W-1:0]     in_sample_x,
  input  logic [tvs_pkg::COORD_W-1:0]     in_sample_y,
  input  logic [tvs_pkg::COORD_W-1:0]     in_sample_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tvs_pkg::VOXEL_W-1:0]     out_sample_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tvs_pkg::tvs_cfg_t                                  cfg_r;
  tvs_pkg::tvs_ram_req_t                              ram_req;
  tvs_pkg::tvs_fwd_t                                  fwd;
  logic [tvs_pkg::N_CORNER-1:0][tvs_pkg::VOXEL_W-1:0] corner_data;
  logic                                               s4_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_size  <= tvs_pkg::RST_SIZE;
      cfg_r.y_size  <= tvs_pkg::RST_SIZE;
      cfg_r.z_size  <= tvs_pkg::RST_SIZE;
      cfg_r.x_org   <= tvs_pkg::RST_ORG;
      cfg_r.y_org   <= tvs_pkg::RST_ORG;
      cfg_r.z_org   <= tvs_pkg::RST_ORG;
      cfg_r.outside <= tvs_pkg::RST_OUTSIDE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvs_pkg::REG_X_SIZE:  cfg_r.x_size  <= tvs_pkg::sat_size(cfg_wdata);
        tvs_pkg::REG_Y_SIZE:  cfg_r.y_size  <= tvs_pkg::sat_size(cfg_wdata);
        tvs_pkg::REG_Z_SIZE:  cfg_r.z_size  <= tvs_pkg::sat_size(cfg_wdata);
        tvs_pkg::REG_X_ORG:   cfg_r.x_org   <= cfg_wdata[tvs_pkg::ORG_W-1:0];
        tvs_pkg::REG_Y_ORG:   cfg_r.y_org   <= cfg_wdata[tvs_pkg::ORG_W-1:0];
        tvs_pkg::REG_Z_ORG:   cfg_r.z_org   <= cfg_wdata[tvs_pkg::ORG_W-1:0];
        tvs_pkg::REG_OUTSIDE: cfg_r.outside <= cfg_wdata[tvs_pkg::VOXEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Address stages.
  tvs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_voxel_index (in_voxel_index),
    .in_voxel_value (in_voxel_value),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .cfg            (cfg_r),
    .s4_ready       (s4_ready),
    .ram_req        (ram_req),
    .fwd            (fwd)
  );

  // Four store copies, each serving a pair of corners that differ along x.
  for (genvar k = 0; k < tvs_pkg::N_BANK; k++) begin : g_bank
    tvs_ram u_ram (
      .clk     (clk),
      .we      (ram_req.we),
      .waddr   (ram_req.waddr),
      .wdata   (ram_req.wdata),
      .re      (ram_req.re),
      .raddr_a (ram_req.raddr[2*k]),
      .raddr_b (ram_req.raddr[2*k+1]),
      .rdata_a (corner_data[2*k]),
      .rdata_b (corner_data[2*k+1])
    );
  end

  // Interpolation stages and output register.
  tvs_interp u_interp (
    .clk              (clk),
    .rst_n            (rst_n),
    .fwd              (fwd),
    .corner_data      (corner_data),
    .outside          (cfg_r.outside),
    .s4_ready         (s4_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for trilinear_volume_sampler_core: voxel loads, samples, register writes.
// Depends on tvs_pkg and the sampler RTL; a scoreboard class predicts every sample beat.
module testbench;

  localparam int VW           = tvs_pkg::VOXEL_W;
  localparam int CW           = tvs_pkg::COORD_W;
  localparam int FW           = tvs_pkg::FRAC_W;
  localparam int TARGET_ITEMS = 1900;
  localparam int PHASE_ITEMS  = 90;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic [tvs_pkg::IDX_W-1:0]     voxel_index;
    logic [VW-1:0]                 voxel_value;
    logic [CW-1:0]                 sample_x;
    logic [CW-1:0]                 sample_y;
    logic [CW-1:0]                 sample_z;
  } volume_item_t;

  // Predicts each sample from its own copy of the registers and the voxel store.
  class volume_scoreboard;
    int x_size, y_size, z_size;
    int x_org, y_org, z_org;
    int outside;
    int voxels[tvs_pkg::VOL_DEPTH];
    bit written[tvs_pkg::VOL_DEPTH];
    logic [VW-1:0] pending_samples[$];
    int n_writes, n_samples, n_checked, n_errors, n_settings;

    function new();
      x_size = tvs_pkg::MAX_EDGE;
      y_size = tvs_pkg::MAX_EDGE;
      z_size = tvs_pkg::MAX_EDGE;
      x_org = -16;
      y_org = -16;
      z_org = -16;
      outside = 0;
    endfunction

    // Sizes use the low six bits and saturate at the store edge.
    function int eff_size(logic [tvs_pkg::CFG_DATA_W-1:0] d);
      int s;
      s = d[tvs_pkg::SIZE_W-1:0];
      return (s > tvs_pkg::MAX_EDGE) ? tvs_pkg::MAX_EDGE : s;
    endfunction

    function void set_reg(logic [tvs_pkg::CFG_IDX_W-1:0] idx,
                          logic [tvs_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        tvs_pkg::REG_X_SIZE:  x_size = eff_size(d);
        tvs_pkg::REG_Y_SIZE:  y_size = eff_size(d);
        tvs_pkg::REG_Z_SIZE:  z_size = eff_size(d);
        tvs_pkg::REG_X_ORG:   x_org = $signed(d[tvs_pkg::ORG_W-1:0]);
        tvs_pkg::REG_Y_ORG:   y_org = $signed(d[tvs_pkg::ORG_W-1:0]);
        tvs_pkg::REG_Z_ORG:   z_org = $signed(d[tvs_pkg::ORG_W-1:0]);
        tvs_pkg::REG_OUTSIDE: outside = $signed(d[VW-1:0]);
        default: ;
      endcase
    endfunction

    // Store address of a logical corner, or -1 when it lies outside the box.
    function int locate(int x, int y, int z);
      int lx, ly, lz;
      lx = x - x_org;
      ly = y - y_org;
      lz = z - z_org;
      if (lx < 0 || lx >= x_size || ly < 0 || ly >= y_size || lz < 0 || lz >= z_size)
        return -1;
      return (lz * y_size + ly) * x_size + lx;
    endfunction

    function int voxel_at(int x, int y, int z);
      int a;
      a = locate(x, y, z);
      return (a < 0) ? outside : voxels[a];
    endfunction

    // True when every corner of the sample is either outside or already loaded.
    function bit sample_ok(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] sz);
      int x0, y0, z0, a;
      x0 = int'($signed(sx)) >>> FW;
      y0 = int'($signed(sy)) >>> FW;
      z0 = int'($signed(sz)) >>> FW;
      for (int i = 0; i < 8; i++) begin
        a = locate(x0 + i[0], y0 + i[1], z0 + i[2]);
        if (a >= 0 && !written[a]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // One linear step, the scaled difference truncated toward zero.
    function int blend(int lo, int hi, int f);
      return lo + ((hi - lo) * f) / (1 << FW);
    endfunction

    function logic [VW-1:0] interpolate(logic [CW-1:0] sx, logic [CW-1:0] sy,
                                        logic [CW-1:0] sz);
      int x0, y0, z0, fx, fy, fz;
      int v[8];
      int ax, bx, cx, dx, ey, gy, rz;
      x0 = int'($signed(sx)) >>> FW;
      y0 = int'($signed(sy)) >>> FW;
      z0 = int'($signed(sz)) >>> FW;
      fx = sx[FW-1:0];
      fy = sy[FW-1:0];
      fz = sz[FW-1:0];
      for (int i = 0; i < 8; i++) v[i] = voxel_at(x0 + i[0], y0 + i[1], z0 + i[2]);
      // Four steps along x, two along y, one along z.
      ax = blend(v[0], v[1], fx);
      cx = blend(v[2], v[3], fx);
      bx = blend(v[4], v[5], fx);
      dx = blend(v[6], v[7], fx);
      ey = blend(ax, cx, fy);
      gy = blend(bx, dx, fy);
      rz = blend(ey, gy, fz);
      return rz[VW-1:0];
    endfunction

    function void note_item(volume_item_t it);
      if (it.mode == MODE_WRITE) begin
        voxels[it.voxel_index] = $signed(it.voxel_value);
        written[it.voxel_index] = 1'b1;
        n_writes++;
      end else begin
        pending_samples.push_back(interpolate(it.sample_x, it.sample_y, it.sample_z));
        n_samples++;
      end
    endfunction

    function void check_result(logic [VW-1:0] got);
      logic [VW-1:0] want;
      n_checked++;
      if (pending_samples.size() == 0) begin
        $error("sample_value: expected no beat, actual %0d", $signed(got));
        n_errors++;
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) begin
          $error("sample_value: expected %0d, actual %0d", $signed(want), $signed(got));
          n_errors++;
        end
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_mode = MODE_WRITE;
  logic [tvs_pkg::IDX_W-1:0]         in_voxel_index = '0;
  logic [VW-1:0]                     in_voxel_value = '0;
  logic [CW-1:0]                     in_sample_x = '0;
  logic [CW-1:0]                     in_sample_y = '0;
  logic [CW-1:0]                     in_sample_z = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [VW-1:0]                     out_sample_value;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [tvs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [tvs_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

  volume_scoreboard sb = new();

  int  burst_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_served = 1'b0;
  int  hold_count = 0;
  int  recv_cycle = 0;
  int  recv_style = 0;
  int  cycle_count = 0;

  trilinear_volume_sampler_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_voxel_index   (in_voxel_index),
    .in_voxel_value   (in_voxel_value),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .in_sample_z      (in_sample_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: changes its stall style every so often, with one long hold-off on request.
  always @(negedge clk) begin
    recv_cycle++;
    if (recv_cycle % 96 == 0) recv_style = $urandom_range(0, 3);
    if (hold_req && !hold_served) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_served = 1'b1;
    end else begin
      case (recv_style)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (recv_cycle % 7 != 3) && (recv_cycle % 5 != 0);
      endcase
    end
  end

  // Every result beat is checked as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_sample_value);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL trilinear_volume_sampler_core");
    $finish;
  end

  function automatic logic [VW-1:0] pick_voxel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return '0;
    return VW'($urandom);
  endfunction

  function automatic volume_item_t write_item(int index, logic [VW-1:0] value);
    volume_item_t it;
    it.mode        = MODE_WRITE;
    it.voxel_index = tvs_pkg::IDX_W'(index);
    it.voxel_value = value;
    it.sample_x    = CW'($urandom);
    it.sample_y    = CW'($urandom);
    it.sample_z    = CW'($urandom);
    return it;
  endfunction

  function automatic volume_item_t sample_item(logic [CW-1:0] sx, logic [CW-1:0] sy,
                                               logic [CW-1:0] sz);
    volume_item_t it;
    it.mode        = MODE_SAMPLE;
    it.voxel_index = tvs_pkg::IDX_W'($urandom);
    it.voxel_value = VW'($urandom);
    it.sample_x    = sx;
    it.sample_y    = sy;
    it.sample_z    = sz;
    return it;
  endfunction

  // A coordinate whose floor lies just around the configured box on one axis.
  function automatic logic [CW-1:0] near_coord(int org, int size);
    int base, r;
    logic [7:0] b8;
    logic [FW-1:0] f;
    base = org + $urandom_range(0, size + 2) - 2;
    r = $urandom_range(0, 6);
    f = (r == 0) ? '0 : (r == 1) ? '1 : FW'($urandom);
    b8 = base[7:0];
    return {b8, f};
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  task automatic send_item(volume_item_t it);
    pace();
    @(negedge clk);
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_voxel_index <= it.voxel_index;
    in_voxel_value <= it.voxel_value;
    in_sample_x    <= it.sample_x;
    in_sample_y    <= it.sample_y;
    in_sample_z    <= it.sample_z;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // Let the pipeline empty, including writes that give no beat.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tvs_pkg::CFG_IDX_W-1:0] idx,
                           logic [tvs_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
  endtask

  // Register setting of one phase: the first three are corner cases with fixed sizes.
  task automatic configure(int ph);
    logic [5:0]  sz[3];
    logic [5:0]  org[3];
    logic [15:0] ov;
    logic [31:0] junk[6];
    int r;
    case (ph)
      0: begin
        sz  = '{6'd32, 6'd1, 6'd1};
        org = '{6'h20, 6'h20, 6'h20};
        ov  = 16'h8000;
      end
      1: begin
        // Size 63 saturates to the store edge.
        sz  = '{6'd1, 6'd63, 6'd2};
        org = '{6'h1F, 6'h1F, 6'h1F};
        ov  = 16'h7FFF;
      end
      2: begin
        // Zero size along x puts every corner outside.
        sz  = '{6'd0, 6'd3, 6'd32};
        org = '{6'($urandom), 6'($urandom), 6'($urandom)};
        ov  = pick_voxel();
      end
      default: begin
        do begin
          for (int k = 0; k < 3; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) sz[k] = 6'd0;
            else if (r == 1) sz[k] = 6'($urandom_range(33, 63));
            else if (r == 2) sz[k] = 6'd32;
            else sz[k] = 6'($urandom_range(1, 6));
          end
        end while (sb.eff_size(16'(sz[0])) * sb.eff_size(16'(sz[1])) *
                   sb.eff_size(16'(sz[2])) > 160);
        for (int k = 0; k < 3; k++) begin
          r = $urandom_range(0, 9);
          org[k] = (r == 0) ? 6'h20 : (r == 1) ? 6'h1F : 6'($urandom);
        end
        ov = pick_voxel();
      end
    endcase
    // Bits above the field are ignored by the block but still toggled here.
    for (int k = 0; k < 6; k++) junk[k] = $urandom;
    write_reg(tvs_pkg::REG_X_SIZE,  {junk[0][9:0], sz[0]});
    write_reg(tvs_pkg::REG_Y_SIZE,  {junk[1][9:0], sz[1]});
    write_reg(tvs_pkg::REG_Z_SIZE,  {junk[2][9:0], sz[2]});
    write_reg(tvs_pkg::REG_X_ORG,   {junk[3][9:0], org[0]});
    write_reg(tvs_pkg::REG_Y_ORG,   {junk[4][9:0], org[1]});
    write_reg(tvs_pkg::REG_Z_ORG,   {junk[5][9:0], org[2]});
    write_reg(tvs_pkg::REG_OUTSIDE, ov);
    @(negedge clk);
    cfg_valid <= 1'b0;
    sb.n_settings++;
  endtask

  // Mostly samples around the box, with stray samples and voxel rewrites mixed in.
  task automatic random_item(int vol);
    volume_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it = sample_item(near_coord(sb.x_org, sb.x_size), near_coord(sb.y_org, sb.y_size),
                       near_coord(sb.z_org, sb.z_size));
    end else if (r < 80) begin
      it = sample_item(CW'($urandom), CW'($urandom), CW'($urandom));
    end else if (r < 90 && vol > 0) begin
      it = write_item($urandom_range(0, vol - 1), pick_voxel());
    end else begin
      it = write_item($urandom_range(0, tvs_pkg::VOL_DEPTH - 1), pick_voxel());
    end
    // Never let a sample touch a voxel that has not been loaded.
    if (it.mode == MODE_SAMPLE && !sb.sample_ok(it.sample_x, it.sample_y, it.sample_z))
      it = write_item($urandom_range(0, tvs_pkg::VOL_DEPTH - 1), pick_voxel());
    send_item(it);
  endtask

  initial begin
    int vol;
    int ph;
    int a;
    logic [VW-1:0] block_vals[8];

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a 2x2x2 block at logical origin under the reset registers, extreme values.
    block_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                   16'd12345, 16'hB1E0, 16'h0001, 16'h7FFF};
    for (int i = 0; i < 8; i++) begin
      a = ((16 + i[2]) * 32 + 16 + i[1]) * 32 + 16 + i[0];
      send_item(write_item(a, block_vals[i]));
    end
    send_item(sample_item(16'h0000, 16'h0000, 16'h0000));
    send_item(sample_item(16'h00FF, 16'h00FF, 16'h00FF));
    send_item(sample_item(16'h0080, 16'h0040, 16'h00C0));
    send_item(sample_item(16'h00FF, 16'h0000, 16'h0001));
    send_item(sample_item(16'h0001, 16'h00FF, 16'h0000));
    send_item(sample_item(16'h8000, 16'h8000, 16'h8000));
    send_item(sample_item(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(sample_item(16'h7FFF, 16'h0000, 16'h8000));
    send_item(write_item(tvs_pkg::VOL_DEPTH - 1, 16'h8000));
    send_item(write_item(0, 16'h7FFF));
    send_item(sample_item(16'h00FF, 16'h00FF, 16'h00FF));
    drain();

    // Phases: set the registers, load the box in use, then random traffic.
    ph = 0;
    while (sb.n_writes + sb.n_samples < TARGET_ITEMS) begin
      configure(ph);
      vol = sb.x_size * sb.y_size * sb.z_size;
      for (int i = 0; i < vol; i++) send_item(write_item(i, pick_voxel()));
      if (ph == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_item(vol);
      drain();
      ph++;
    end

    $display("Run covered %0d voxel writes and %0d samples over %0d register settings.",
             sb.n_writes, sb.n_samples, sb.n_settings);
    $display("%0d result beats checked, %0d mismatches.", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("PASS trilinear_volume_sampler_core");
    else
      $display("FAIL trilinear_volume_sampler_core");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tvs_pkg.sv
rtl/core/tvs_ram.sv
rtl/core/tvs_front.sv
rtl/core/tvs_interp.sv
rtl/core/trilinear_volume_sampler_core.sv
verif/testbench.sv
